[rtl/fdlf_pkg.sv]
// ---------------------------------------------------------------------------
// fdlf_pkg
// Shared constants, types and helpers of the fractional feedback delay line.
// ---------------------------------------------------------------------------
package fdlf_pkg;

    // Delay memory geometry
    localparam int ADDR_BITS = 17;
    localparam int DEPTH     = 1 << ADDR_BITS;

    // Sample and distance formats
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int DIST_BITS   = ADDR_BITS + FRAC_BITS;

    // Configuration port
    localparam int CFG_BITS       = 17;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_DELAY = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_MIX   = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_GAIN  = CFG_INDEX_BITS'(2);

    // Unsigned Q1.16 gains, unity included
    localparam int Q16_BITS  = 17;
    localparam int Q16_SHIFT = 16;
    localparam int UNITY_Q16 = 1 << Q16_SHIFT;

    // One-pole smoother coefficient 0.1 in Q0.16
    localparam int COEF_BITS = 15;
    localparam logic signed [COEF_BITS-1:0] SMOOTH_COEF = COEF_BITS'(6554);

    // Width of the feedback and blend accumulators before saturation
    localparam int SAT_IN_BITS = SAMPLE_BITS + Q16_BITS + 3;
    localparam logic signed [SAT_IN_BITS-1:0] HALF_Q16 =
        SAT_IN_BITS'(1) <<< (Q16_SHIFT - 1);

    // Width of the interpolation accumulator
    localparam int INTERP_BITS = SAMPLE_BITS + FRAC_BITS + 3;

    // Read request: both neighbors at once
    typedef struct packed {
        logic                 en;
        logic [ADDR_BITS-1:0] addr_a;
        logic [ADDR_BITS-1:0] addr_b;
    } rd_req_t;

    // Read response, in the cycle after the request
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] data_a;
        logic [SAMPLE_BITS-1:0] data_b;
    } rd_rsp_t;

    // Write request
    typedef struct packed {
        logic                   we;
        logic [ADDR_BITS-1:0]   addr;
        logic [SAMPLE_BITS-1:0] data;
    } wr_req_t;

    // Saturate a wide signed value to the sample range
    function automatic logic [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [SAT_IN_BITS-1:0] v
    );
        logic [SAT_IN_BITS-SAMPLE_BITS:0] upper;
        upper = v[SAT_IN_BITS-1:SAMPLE_BITS-1];
        if ((&upper) || !(|upper))
        begin
            sat_sample = v[SAMPLE_BITS-1:0];
        end
        else if (upper[SAT_IN_BITS-SAMPLE_BITS])
        begin
            sat_sample = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            sat_sample = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    endfunction

endpackage

[rtl/fdlf_delay_ram.sv]
// ---------------------------------------------------------------------------
// fdlf_delay_ram
// Circular sample store: one write port, two registered read ports. Entries
// not yet written read as zero, tracked by a fill count (writes are strictly
// sequential from address zero, so entry i is written once fill > i).
// ---------------------------------------------------------------------------
module fdlf_delay_ram (
    input  logic              clk,
    input  logic              rst_n,
    input  fdlf_pkg::rd_req_t rd_req,
    input  fdlf_pkg::wr_req_t wr_req,
    output fdlf_pkg::rd_rsp_t rd_rsp
);

    logic [fdlf_pkg::SAMPLE_BITS-1:0] mem [fdlf_pkg::DEPTH];

    logic [fdlf_pkg::SAMPLE_BITS-1:0] data_a_reg;
    logic [fdlf_pkg::SAMPLE_BITS-1:0] data_b_reg;
    logic                             ok_a_reg;
    logic                             ok_b_reg;
    logic [fdlf_pkg::ADDR_BITS:0]     fill_reg;
    logic [fdlf_pkg::ADDR_BITS:0]     fill_next;

    // Fill count saturates at the depth
    always_comb
    begin
        fill_next = fill_reg;
        if (wr_req.we && (fill_reg != (fdlf_pkg::ADDR_BITS+1)'(fdlf_pkg::DEPTH)))
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    // Storage array, write and two reads
    always_ff @(posedge clk)
    begin
        if (wr_req.we)
        begin
            mem[wr_req.addr] <= wr_req.data;
        end
        if (rd_req.en)
        begin
            data_a_reg <= mem[rd_req.addr_a];
            data_b_reg <= mem[rd_req.addr_b];
            ok_a_reg   <= fill_reg > {1'b0, rd_req.addr_a};
            ok_b_reg   <= fill_reg > {1'b0, rd_req.addr_b};
        end
    end

    // Unwritten entries read as zero
    assign rd_rsp.data_a = ok_a_reg ? data_a_reg : '0;
    assign rd_rsp.data_b = ok_b_reg ? data_b_reg : '0;

endmodule

[rtl/feedback_delay_line_fractional_core.sv]
// ---------------------------------------------------------------------------
// feedback_delay_line_fractional_core
// Feedback echo with linearly interpolated fractional read position.
// Steps: smooth, read RAM, interpolate, mix/write back; the result is registered at
//   the end of the mix step, which waits while the output is held. The next beat is
//   taken in the last cycle of the current one, so one beat is worked on at a time.
// Reset: control state, write pointer and smoothers cleared; the RAM is not
//   swept, a fill count makes unwritten entries read zero (no clearing pass).
// ---------------------------------------------------------------------------
module feedback_delay_line_fractional_core (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [fdlf_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [fdlf_pkg::CFG_BITS-1:0]           cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [fdlf_pkg::SAMPLE_BITS-1:0] sample_in,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [fdlf_pkg::SAMPLE_BITS-1:0] sample_out
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SMOOTH = 5'b00010,
        ST_READ   = 5'b00100,
        ST_INTERP = 5'b01000,
        ST_MIX    = 5'b10000
    } state_t;

    localparam logic [fdlf_pkg::DIST_BITS-1:0] DIST_ONE =
        fdlf_pkg::DIST_BITS'(1) << fdlf_pkg::FRAC_BITS;

    state_t state_reg;
    state_t state_next;

    logic [fdlf_pkg::ADDR_BITS-1:0]          cfg_delay_reg;
    logic [fdlf_pkg::Q16_BITS-1:0]           cfg_mix_reg;
    logic [fdlf_pkg::Q16_BITS-1:0]           cfg_gain_reg;
    logic [fdlf_pkg::DIST_BITS-1:0]          dist_reg;
    logic [fdlf_pkg::Q16_BITS-1:0]           mix_reg;
    logic [fdlf_pkg::ADDR_BITS-1:0]          wp_reg;
    logic signed [fdlf_pkg::SAMPLE_BITS-1:0] x_reg;
    logic [fdlf_pkg::FRAC_BITS-1:0]          frac_reg;
    logic signed [fdlf_pkg::SAMPLE_BITS-1:0] delayed_reg;
    logic                                    out_valid_reg;
    logic [fdlf_pkg::SAMPLE_BITS-1:0]        out_sample_reg;

    logic out_free;
    logic finish;
    logic in_take;
    logic mix_on;

    fdlf_pkg::rd_req_t rd_req;
    fdlf_pkg::rd_rsp_t rd_rsp;
    fdlf_pkg::wr_req_t wr_req;

    // Handshake
    assign cfg_ready  = 1'b1;
    assign out_free   = !out_valid_reg || out_ready;
    assign finish     = (state_reg == ST_MIX) && out_free;
    assign in_ready   = (state_reg == ST_IDLE) || finish;
    assign in_take    = in_valid && in_ready;
    assign mix_on     = mix_reg != '0;
    assign out_valid  = out_valid_reg;
    assign sample_out = out_sample_reg;

    // Distance smoother, floored at one sample
    logic signed [fdlf_pkg::DIST_BITS:0]                     dist_diff;
    logic signed [fdlf_pkg::DIST_BITS+fdlf_pkg::COEF_BITS:0] dist_prod;
    logic signed [fdlf_pkg::DIST_BITS+fdlf_pkg::COEF_BITS:0] dist_shift;
    logic signed [fdlf_pkg::DIST_BITS:0]                     dist_sum;
    logic [fdlf_pkg::DIST_BITS-1:0]                          dist_next;

    always_comb
    begin
        dist_diff  = $signed({1'b0, cfg_delay_reg, {fdlf_pkg::FRAC_BITS{1'b0}}})
                   - $signed({1'b0, dist_reg});
        dist_prod  = dist_diff * fdlf_pkg::SMOOTH_COEF;
        dist_shift = dist_prod >>> fdlf_pkg::Q16_SHIFT;
        dist_sum   = $signed({1'b0, dist_reg}) + $signed(dist_shift[fdlf_pkg::DIST_BITS:0]);
        dist_next  = (dist_sum[fdlf_pkg::DIST_BITS-1:0] < DIST_ONE)
                   ? DIST_ONE : dist_sum[fdlf_pkg::DIST_BITS-1:0];
    end

    // Mix smoother
    logic signed [fdlf_pkg::Q16_BITS:0]                     mix_diff;
    logic signed [fdlf_pkg::Q16_BITS+fdlf_pkg::COEF_BITS:0] mix_prod;
    logic signed [fdlf_pkg::Q16_BITS+fdlf_pkg::COEF_BITS:0] mix_shift;
    logic signed [fdlf_pkg::Q16_BITS:0]                     mix_sum;

    always_comb
    begin
        mix_diff  = $signed({1'b0, cfg_mix_reg}) - $signed({1'b0, mix_reg});
        mix_prod  = mix_diff * fdlf_pkg::SMOOTH_COEF;
        mix_shift = mix_prod >>> fdlf_pkg::Q16_SHIFT;
        mix_sum   = $signed({1'b0, mix_reg}) + $signed(mix_shift[fdlf_pkg::Q16_BITS:0]);
    end

    // Read position behind the write pointer, wraps modulo the span
    logic [fdlf_pkg::DIST_BITS-1:0] read_pos;

    always_comb
    begin
        read_pos      = {wp_reg, {fdlf_pkg::FRAC_BITS{1'b0}}} - dist_reg;
        rd_req.en     = state_reg == ST_READ;
        rd_req.addr_a = read_pos[fdlf_pkg::DIST_BITS-1:fdlf_pkg::FRAC_BITS];
        rd_req.addr_b = rd_req.addr_a + fdlf_pkg::ADDR_BITS'(1);
    end

    // Linear interpolation: a + (b - a) * frac, rounded
    logic signed [fdlf_pkg::SAMPLE_BITS-1:0]                    samp_a;
    logic signed [fdlf_pkg::SAMPLE_BITS-1:0]                    samp_b;
    logic signed [fdlf_pkg::SAMPLE_BITS:0]                      ab_diff;
    logic signed [fdlf_pkg::SAMPLE_BITS+fdlf_pkg::FRAC_BITS+1:0] ab_prod;
    logic signed [fdlf_pkg::INTERP_BITS-1:0]                    a_wide;
    logic signed [fdlf_pkg::INTERP_BITS-1:0]                    interp_acc;
    logic signed [fdlf_pkg::INTERP_BITS-1:0]                    interp_shift;

    always_comb
    begin
        samp_a       = $signed(rd_rsp.data_a);
        samp_b       = $signed(rd_rsp.data_b);
        ab_diff      = $signed({samp_b[fdlf_pkg::SAMPLE_BITS-1], samp_b})
                     - $signed({samp_a[fdlf_pkg::SAMPLE_BITS-1], samp_a});
        ab_prod      = ab_diff * $signed({1'b0, frac_reg});
        a_wide       = samp_a;
        interp_acc   = (a_wide <<< fdlf_pkg::FRAC_BITS) + ab_prod
                     + (fdlf_pkg::INTERP_BITS'(1) <<< (fdlf_pkg::FRAC_BITS - 1));
        interp_shift = interp_acc >>> fdlf_pkg::FRAC_BITS;
    end

    // Feedback write-back value and dry/wet blend
    logic signed [fdlf_pkg::SAT_IN_BITS-1:0] x_wide;
    logic signed [fdlf_pkg::SAT_IN_BITS-1:0] fb_acc;
    logic signed [fdlf_pkg::SAT_IN_BITS-1:0] fb_sum;
    logic signed [fdlf_pkg::SAMPLE_BITS:0]   dx_diff;
    logic signed [fdlf_pkg::SAT_IN_BITS-1:0] blend_acc;
    logic [fdlf_pkg::SAMPLE_BITS-1:0]        result;

    always_comb
    begin
        x_wide    = x_reg;
        fb_acc    = delayed_reg * $signed({1'b0, cfg_gain_reg}) + fdlf_pkg::HALF_Q16;
        fb_sum    = x_wide + (fb_acc >>> fdlf_pkg::Q16_SHIFT);
        dx_diff   = $signed({delayed_reg[fdlf_pkg::SAMPLE_BITS-1], delayed_reg})
                  - $signed({x_reg[fdlf_pkg::SAMPLE_BITS-1], x_reg});
        blend_acc = (x_wide <<< fdlf_pkg::Q16_SHIFT)
                  + dx_diff * $signed({1'b0, mix_reg}) + fdlf_pkg::HALF_Q16;
        result    = mix_on ? fdlf_pkg::sat_sample(blend_acc >>> fdlf_pkg::Q16_SHIFT)
                  : x_reg;

        wr_req.we   = finish && mix_on;
        wr_req.addr = wp_reg;
        wr_req.data = fdlf_pkg::sat_sample(fb_sum);
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SMOOTH;
                end
            end
            ST_SMOOTH: state_next = ST_READ;
            ST_READ:   state_next = ST_INTERP;
            ST_INTERP: state_next = ST_MIX;
            ST_MIX:
            begin
                if (out_free)
                begin
                    state_next = in_valid ? ST_SMOOTH : ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control, configuration and recurrent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cfg_delay_reg <= fdlf_pkg::ADDR_BITS'(1);
            cfg_mix_reg   <= '0;
            cfg_gain_reg  <= '0;
            dist_reg      <= '0;
            mix_reg       <= '0;
            wp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Register writes, clamped to their usable range
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    fdlf_pkg::CFG_IDX_DELAY:
                    begin
                        if (cfg_data == '0)
                        begin
                            cfg_delay_reg <= fdlf_pkg::ADDR_BITS'(1);
                        end
                        else if (int'(cfg_data) > fdlf_pkg::DEPTH - 1)
                        begin
                            cfg_delay_reg <= fdlf_pkg::ADDR_BITS'(fdlf_pkg::DEPTH - 1);
                        end
                        else
                        begin
                            cfg_delay_reg <= fdlf_pkg::ADDR_BITS'(cfg_data);
                        end
                    end
                    fdlf_pkg::CFG_IDX_MIX:
                    begin
                        cfg_mix_reg <= (int'(cfg_data) > fdlf_pkg::UNITY_Q16)
                                     ? fdlf_pkg::Q16_BITS'(fdlf_pkg::UNITY_Q16)
                                     : fdlf_pkg::Q16_BITS'(cfg_data);
                    end
                    fdlf_pkg::CFG_IDX_GAIN:
                    begin
                        cfg_gain_reg <= (int'(cfg_data) > fdlf_pkg::UNITY_Q16)
                                      ? fdlf_pkg::Q16_BITS'(fdlf_pkg::UNITY_Q16)
                                      : fdlf_pkg::Q16_BITS'(cfg_data);
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (state_reg == ST_SMOOTH)
            begin
                dist_reg <= dist_next;
                mix_reg  <= mix_sum[fdlf_pkg::Q16_BITS-1:0];
            end

            if (wr_req.we)
            begin
                wp_reg <= wp_reg + fdlf_pkg::ADDR_BITS'(1);
            end

            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            x_reg <= sample_in;
        end
        if (state_reg == ST_READ)
        begin
            frac_reg <= read_pos[fdlf_pkg::FRAC_BITS-1:0];
        end
        if (state_reg == ST_INTERP)
        begin
            delayed_reg <= interp_shift[fdlf_pkg::SAMPLE_BITS-1:0];
        end
        if (finish)
        begin
            out_sample_reg <= result;
        end
    end

    // Delay memory
    fdlf_delay_ram u_delay_ram (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_req (rd_req),
        .wr_req (wr_req),
        .rd_rsp (rd_rsp)
    );

endmodule
